// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the polygon area block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on clk_i, switched off while rst_ni is low.
`define PSA_ASSERT_I(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

// Checked on clk_i at every edge, reset included.
`define PSA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("%m: assertion failed");

`endif

// ----- hw/rtl/psa_pkg.sv -----
// ----------------------------------------------------------------------------
// psa_pkg
// Types, constants and helpers shared by the polygon area block.
// ----------------------------------------------------------------------------
`default_nettype none

package psa_pkg;

  localparam int COORD_BITS_DEF  = 24;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int SUM_W           = 64;
  localparam int AREA_W          = 62;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Vertices seen in the current polygon, saturating at three or more
  typedef enum logic [1:0] {
    CNT_NONE,
    CNT_ONE,
    CNT_TWO,
    CNT_MANY
  } vtx_cnt_e;

  // Per-request control from front to back
  typedef struct packed {
    logic acc;      // add the edge product to the running sum
    logic last;     // closes the polygon
    logic too_few;  // polygon has fewer than three vertices
  } vtx_ctl_t;

  // Signed add that clamps to the 64-bit range
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/psa_if.sv -----
// ----------------------------------------------------------------------------
// psa_if
// Valid/ready channels for vertex requests and area results.
// ----------------------------------------------------------------------------
`default_nettype none

interface psa_vertex_if #(
  parameter int COORD_BITS = psa_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

interface psa_area_if ();
  logic                        valid;
  logic                        ready;
  logic [psa_pkg::AREA_W-1:0]  twice_area;
  logic                        too_few_vertices;

  modport source (output valid, output twice_area, output too_few_vertices,
                  input ready);
  modport sink   (input valid, input twice_area, input too_few_vertices,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/psa_front.sv -----
// ----------------------------------------------------------------------------
// psa_front
// Accepts vertices, tracks the polygon's history and builds the operands
// of the edge product and the two closing products.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module psa_front #(
  parameter int COORD_BITS = psa_pkg::COORD_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  psa_vertex_if.sink                  vtx_i,
  input  wire logic                   q_full_i,
  output logic                        q_push_o,
  output psa_pkg::vtx_ctl_t           ctl_o,
  output logic [6*COORD_BITS+2:0]     ops_o
);
  import psa_pkg::*;

  localparam int CW = COORD_BITS;

  vtx_cnt_e cnt_q, cnt_d;
  logic     accept;

  logic [CW-1:0] first_x_q, first_y_q, second_y_q;
  logic [CW-1:0] older_y_q, newer_x_q, newer_y_q;
  logic [CW:0]   mul_b, w1_b, w2_b;

  assign vtx_i.ready = !q_full_i;
  assign accept      = vtx_i.valid && !q_full_i;
  assign q_push_o    = accept;

  // Vertex count: next state
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (vtx_i.last_vertex) begin
        cnt_d = CNT_NONE;
      end else begin
        unique case (cnt_q)
          CNT_NONE: cnt_d = CNT_ONE;
          CNT_ONE:  cnt_d = CNT_TWO;
          CNT_TWO:  cnt_d = CNT_MANY;
          CNT_MANY: cnt_d = CNT_MANY;
          default:  cnt_d = CNT_NONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_NONE;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Vertex history; only read once written within the polygon
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (cnt_q == CNT_NONE) begin
        first_x_q <= vtx_i.vertex_x;
        first_y_q <= vtx_i.vertex_y;
      end
      if (cnt_q == CNT_ONE) begin
        second_y_q <= vtx_i.vertex_y;
      end
      older_y_q <= newer_y_q;
      newer_x_q <= vtx_i.vertex_x;
      newer_y_q <= vtx_i.vertex_y;
    end
  end

  // Classification and operand build
  always_comb begin
    ctl_o.acc     = (cnt_q == CNT_TWO) || (cnt_q == CNT_MANY);
    ctl_o.last    = vtx_i.last_vertex;
    ctl_o.too_few = (cnt_q == CNT_NONE) || (cnt_q == CNT_ONE);

    // edge: x(prev) * (y - y(prev of prev))
    mul_b = {vtx_i.vertex_y[CW-1], vtx_i.vertex_y} - {older_y_q[CW-1], older_y_q};
    // closing: x * (y(first) - y(prev)) and x(first) * (y(second) - y)
    w1_b  = {first_y_q[CW-1], first_y_q} - {newer_y_q[CW-1], newer_y_q};
    w2_b  = {second_y_q[CW-1], second_y_q} - {vtx_i.vertex_y[CW-1], vtx_i.vertex_y};

    ops_o = {newer_x_q, mul_b, vtx_i.vertex_x, w1_b, first_x_q, w2_b};
  end

  `PSA_ASSERT_I(a_front_last_clears, accept && vtx_i.last_vertex |=> cnt_q == CNT_NONE)

endmodule

`default_nettype wire

// ----- hw/rtl/psa_queue.sv -----
// ----------------------------------------------------------------------------
// psa_queue
// Small FIFO that decouples the vertex front from the arithmetic back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module psa_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = psa_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);

  `PSA_ASSERT_I(a_queue_no_overflow, push_i |-> !full_o)
  `PSA_ASSERT_I(a_queue_no_underflow, pop_i |-> !empty_o)

endmodule

`default_nettype wire

// ----- hw/rtl/psa_back.sv -----
// ----------------------------------------------------------------------------
// psa_back
// Multiplies, accumulates with saturation, closes the polygon and holds
// the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module psa_back #(
  parameter int COORD_BITS = psa_pkg::COORD_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   q_empty_i,
  output logic                        q_pop_o,
  input  wire psa_pkg::vtx_ctl_t      ctl_i,
  input  wire logic [6*COORD_BITS+2:0] ops_i,
  psa_area_if.source                  area_o
);
  import psa_pkg::*;

  localparam int CW     = COORD_BITS;
  localparam int PROD_W = 2 * COORD_BITS + 1;

  logic en;

  // Unpacked operands
  logic signed [CW-1:0] mul_a, w1_a, w2_a;
  logic signed [CW:0]   mul_b, w1_b, w2_b;

  // Stage 1: products
  logic                     s1_v_q;
  vtx_ctl_t                 s1_ctl_q;
  logic signed [PROD_W-1:0] p0_q, w1p_q, w2p_q;

  // Stage 2: accumulator
  logic signed [SUM_W-1:0]  sum_q, sum_acc;
  logic                     s2_v_q, s2_few_q;
  logic signed [SUM_W-1:0]  s2_part_q;
  logic signed [PROD_W-1:0] s2_w1_q, s2_w2_q;

  // Stage 3 and 4: closing terms
  logic                     s3_v_q, s3_few_q, s4_v_q, s4_few_q;
  logic signed [SUM_W-1:0]  s3_part_q, s4_sum_q;
  logic signed [PROD_W-1:0] s3_w2_q;

  // Output register
  logic                     out_v_q, out_few_q;
  logic [AREA_W-1:0]        out_area_q;
  logic [SUM_W-1:0]         mag;

  assign {mul_a, mul_b, w1_a, w1_b, w2_a, w2_b} = ops_i;

  // The whole pipe advances when the output slot is free
  assign en      = !out_v_q || area_o.ready;
  assign q_pop_o = en && !q_empty_i;

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= q_pop_o;
      s2_v_q  <= s1_v_q && s1_ctl_q.last;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      out_v_q <= s4_v_q;
    end
  end

  // Running sum, cleared once a polygon closes
  assign sum_acc = s1_ctl_q.acc ? sat_add(sum_q, SUM_W'(p0_q)) : sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en && s1_v_q) begin
      sum_q <= s1_ctl_q.last ? '0 : sum_acc;
    end
  end

  // Magnitude of the closed sum
  assign mag = s4_sum_q[SUM_W-1] ? SUM_W'(-s4_sum_q) : s4_sum_q;

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ctl_q  <= ctl_i;
      p0_q      <= mul_a * mul_b;
      w1p_q     <= w1_a * w1_b;
      w2p_q     <= w2_a * w2_b;

      s2_part_q <= sum_acc;
      s2_w1_q   <= w1p_q;
      s2_w2_q   <= w2p_q;
      s2_few_q  <= s1_ctl_q.too_few;

      s3_part_q <= sat_add(s2_part_q, SUM_W'(s2_w1_q));
      s3_w2_q   <= s2_w2_q;
      s3_few_q  <= s2_few_q;

      s4_sum_q  <= sat_add(s3_part_q, SUM_W'(s3_w2_q));
      s4_few_q  <= s3_few_q;

      out_few_q <= s4_few_q;
      if (s4_few_q) begin
        out_area_q <= '0;
      end else if (mag[SUM_W-1:AREA_W] != '0) begin
        out_area_q <= '1;
      end else begin
        out_area_q <= mag[AREA_W-1:0];
      end
    end
  end

  assign area_o.valid            = out_v_q;
  assign area_o.twice_area       = out_area_q;
  assign area_o.too_few_vertices = out_few_q;

  `PSA_ASSERT_I(a_back_sum_cleared, en && s1_v_q && s1_ctl_q.last |=> sum_q == '0)
  `PSA_ASSERT_I(a_back_stall_no_pop, area_o.valid && !area_o.ready |-> !q_pop_o)

endmodule

`default_nettype wire

// ----- hw/rtl/polygon_area_shoelace.sv -----
// Streaming shoelace polygon area. Vertices arrive one request per cycle on
// vtx_i, the final one flagged by last_vertex; one result per polygon leaves
// on area_o with |shoelace sum| (twice the area, saturating at 2^62-1) or a
// too_few_vertices flag and zero for polygons of one or two vertices. A new
// vertex is taken every cycle while the queue has room; the last vertex
// passes through the queue into the product registers, then through the
// saturating accumulator, the closing adds and the output register. While
// a result waits on area_o the arithmetic pipe holds and up to QUEUE_DEPTH
// vertices gather in the queue before vtx_i.ready drops.
// ----------------------------------------------------------------------------
// polygon_area_shoelace
// Top level: vertex front, decoupling queue and arithmetic back.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_area_shoelace #(
  parameter int COORD_BITS  = psa_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = psa_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  psa_vertex_if.sink vtx_i,
  psa_area_if.source area_o
);
  import psa_pkg::*;

  localparam int OPS_W   = 6 * COORD_BITS + 3;
  localparam int ENTRY_W = $bits(vtx_ctl_t) + OPS_W;

  vtx_ctl_t           front_ctl, back_ctl;
  logic [OPS_W-1:0]   front_ops, back_ops;
  logic               q_push, q_pop, q_full, q_empty;
  logic [ENTRY_W-1:0] q_rdata;

  psa_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vtx_i    (vtx_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .ctl_o    (front_ctl),
    .ops_o    (front_ops)
  );

  psa_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({front_ctl, front_ops}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  assign {back_ctl, back_ops} = q_rdata;

  psa_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .ctl_i     (back_ctl),
    .ops_i     (back_ops),
    .area_o    (area_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming shoelace area block: vertex requests
// go in through bursty traffic, closed polygons come back as twice-area
// results that are checked against a cycle-free predictor of the datapath.
// ----------------------------------------------------------------------------

module tb;

  localparam int COORD_W        = psa_pkg::COORD_BITS_DEF;
  localparam int DIRECTED_ROWS  = 24;
  localparam int RANDOM_ITEMS   = 1900;
  localparam int SETTLE_CYCLES  = 20;
  localparam int CYCLE_LIMIT    = 2000000;

  typedef logic signed [COORD_W-1:0]          coord_t;
  typedef logic signed [psa_pkg::SUM_W-1:0]   sum_t;

  typedef struct packed {
    logic [psa_pkg::AREA_W-1:0] twice_area;
    logic                       too_few;
  } area_res_t;

  typedef struct packed {
    coord_t    x;
    coord_t    y;
    logic      last;
    logic      typed;   // result below is known by inspection
    area_res_t res;
  } vertex_row_t;

  localparam coord_t                     C_MAX    = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t                     C_MIN    = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [psa_pkg::AREA_W-1:0] AREA_TOP = '1;

  logic clk;
  logic rst_n;

  psa_vertex_if #(.COORD_BITS(COORD_W)) vtx_if ();
  psa_area_if                           area_if ();

  polygon_area_shoelace u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .vtx_i  (vtx_if),
    .area_o (area_if)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Directed polygons: degenerate sizes, extremes, both orientations
  vertex_row_t directed_rows [DIRECTED_ROWS] = '{
    // one vertex
    '{C_MAX, C_MIN, 1'b1, 1'b1, '{62'd0, 1'b1}},
    // two vertices
    '{C_MIN, C_MAX, 1'b0, 1'b0, '0},
    '{C_MAX, C_MIN, 1'b1, 1'b1, '{62'd0, 1'b1}},
    // small counter-clockwise triangle
    '{24'sd0, 24'sd0, 1'b0, 1'b0, '0},
    '{24'sd2, 24'sd0, 1'b0, 1'b0, '0},
    '{24'sd0, 24'sd2, 1'b1, 1'b1, '{62'd4, 1'b0}},
    // extreme triangle
    '{C_MIN, C_MIN, 1'b0, 1'b0, '0},
    '{C_MAX, C_MIN, 1'b0, 1'b0, '0},
    '{C_MIN, C_MAX, 1'b1, 1'b0, '0},
    // clockwise unit square
    '{24'sd0, 24'sd0, 1'b0, 1'b0, '0},
    '{24'sd0, 24'sd1, 1'b0, 1'b0, '0},
    '{24'sd1, 24'sd1, 1'b0, 1'b0, '0},
    '{24'sd1, 24'sd0, 1'b1, 1'b1, '{62'd2, 1'b0}},
    // three coincident points
    '{24'sd0, 24'sd0, 1'b0, 1'b0, '0},
    '{24'sd0, 24'sd0, 1'b0, 1'b0, '0},
    '{24'sd0, 24'sd0, 1'b1, 1'b1, '{62'd0, 1'b0}},
    // collinear
    '{24'sd1, 24'sd1, 1'b0, 1'b0, '0},
    '{24'sd2, 24'sd2, 1'b0, 1'b0, '0},
    '{24'sd3, 24'sd3, 1'b0, 1'b0, '0},
    '{-24'sd5, -24'sd5, 1'b1, 1'b0, '0},
    // full-range square
    '{C_MIN, C_MIN, 1'b0, 1'b0, '0},
    '{C_MAX, C_MIN, 1'b0, 1'b0, '0},
    '{C_MAX, C_MAX, 1'b0, 1'b0, '0},
    '{C_MIN, C_MAX, 1'b1, 1'b0, '0}
  };

  // Predictor state
  coord_t             poly_first_x, poly_first_y, poly_second_y;
  coord_t             poly_older_x, poly_older_y, poly_newer_x, poly_newer_y;
  sum_t               poly_sum;
  psa_pkg::vtx_cnt_e  poly_count;

  area_res_t pending_areas [$];
  int        mismatches;
  int        vertices_sent;
  int        burst_left;
  int        steady_left;
  int        hold_req;
  int        cycle_count;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR %0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void clear_polygon();
    poly_first_x  = '0;
    poly_first_y  = '0;
    poly_second_y = '0;
    poly_older_x  = '0;
    poly_older_y  = '0;
    poly_newer_x  = '0;
    poly_newer_y  = '0;
    poly_sum      = '0;
    poly_count    = psa_pkg::CNT_NONE;
  endfunction

  // x * (y_a - y_b) at full precision
  function automatic sum_t cross_term(input coord_t x, input coord_t ya, input coord_t yb);
    sum_t dy;
    sum_t xs;
    dy = sum_t'(ya) - sum_t'(yb);
    xs = sum_t'(x);
    return xs * dy;
  endfunction

  // Add clamped to the signed 64-bit range
  function automatic sum_t clamp_sum_add(input sum_t a, input sum_t b);
    logic signed [psa_pkg::SUM_W:0] wide;
    wide = a + b;
    if (wide > $signed({1'b0, psa_pkg::SUM_MAX})) return psa_pkg::SUM_MAX;
    if (wide < $signed({1'b1, psa_pkg::SUM_MIN})) return psa_pkg::SUM_MIN;
    return wide[psa_pkg::SUM_W-1:0];
  endfunction

  // Advance the polygon by one vertex; returns 1 when a result is due
  function automatic bit shoelace_step(input coord_t x, input coord_t y, input logic last,
                                       output area_res_t res);
    psa_pkg::vtx_cnt_e seen;
    sum_t              total;
    logic [63:0]       mag;
    seen = poly_count;
    res  = '0;
    case (seen)
      psa_pkg::CNT_NONE: begin
        poly_first_x = x;
        poly_first_y = y;
      end
      psa_pkg::CNT_ONE: begin
        poly_second_y = y;
      end
      default: begin
        poly_sum = clamp_sum_add(poly_sum, cross_term(poly_newer_x, y, poly_older_y));
      end
    endcase
    poly_older_x = poly_newer_x;
    poly_older_y = poly_newer_y;
    poly_newer_x = x;
    poly_newer_y = y;
    if (poly_count != psa_pkg::CNT_MANY) poly_count = psa_pkg::vtx_cnt_e'(poly_count + 2'd1);
    if (!last) return 1'b0;

    if (seen == psa_pkg::CNT_NONE || seen == psa_pkg::CNT_ONE) begin
      res.too_few = 1'b1;
    end else begin
      // closing edges back to the first vertex
      total = clamp_sum_add(poly_sum, cross_term(poly_newer_x, poly_first_y, poly_older_y));
      total = clamp_sum_add(total, cross_term(poly_first_x, poly_second_y, poly_newer_y));
      mag = (total < 0) ? (64'd0 - 64'(total)) : 64'(total);
      if (mag > {2'b00, AREA_TOP}) mag = {2'b00, AREA_TOP};
      res.twice_area = mag[psa_pkg::AREA_W-1:0];
    end
    clear_polygon();
    return 1'b1;
  endfunction

  // Offer one vertex, wait for acceptance, then maybe leave a gap
  task automatic offer_vertex(input coord_t x, input coord_t y, input logic last,
                              input logic typed, input area_res_t typed_res);
    area_res_t predicted;
    vtx_if.valid       <= 1'b1;
    vtx_if.vertex_x    <= x;
    vtx_if.vertex_y    <= y;
    vtx_if.last_vertex <= last;
    do @(posedge clk); while (!vtx_if.ready);
    vertices_sent++;
    if (shoelace_step(x, y, last, predicted)) begin
      pending_areas.push_back(typed ? typed_res : predicted);
    end
    if (steady_left > 0) begin
      steady_left--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      vtx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(0, 20);
    end
  endtask

  // Hold the sender off until every result is back
  task automatic wait_for_results();
    vtx_if.valid <= 1'b0;
    while (pending_areas.size() != 0) @(posedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2: return coord_t'($urandom);
      3: begin
        case ($urandom_range(0, 4))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return '0;
          3:       return -24'sd1;
          default: return 24'sd1;
        endcase
      end
      default: return coord_t'($urandom_range(0, 2000)) - 24'sd1000;
    endcase
  endfunction

  // Area results: check, then pick next ready from a rotating stall pattern
  int  rx_cycles;
  int  hold_left;
  logic take;
  always @(posedge clk) begin
    if (!rst_n) begin
      area_if.ready <= 1'b0;
    end else begin
      if (area_if.valid && area_if.ready) begin
        if (pending_areas.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(area_if.twice_area), 64'd0);
        end else begin
          area_res_t want;
          want = pending_areas.pop_front();
          if (area_if.twice_area !== want.twice_area)
            report_mismatch("twice_area", 64'(area_if.twice_area), 64'(want.twice_area));
          if (area_if.too_few_vertices !== want.too_few)
            report_mismatch("too_few_vertices", 64'(area_if.too_few_vertices),
                            64'(want.too_few));
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        case ((rx_cycles / 97) % 4)
          0:       take = 1'b1;
          1:       take = ($urandom_range(0, 3) != 0);
          2:       take = ($urandom_range(0, 3) == 0);
          default: take = (rx_cycles % 3 != 0);
        endcase
      end
      rx_cycles++;
      area_if.ready <= take;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int  poly_size;
    bit  held;
    bit  paused;
    vtx_if.valid       = 1'b0;
    vtx_if.vertex_x    = '0;
    vtx_if.vertex_y    = '0;
    vtx_if.last_vertex = 1'b0;
    area_if.ready      = 1'b0;
    rst_n              = 1'b0;
    mismatches    = 0;
    vertices_sent = 0;
    burst_left    = 0;
    steady_left   = 0;
    hold_req      = 0;
    cycle_count   = 0;
    rx_cycles     = 0;
    hold_left     = 0;
    held          = 1'b0;
    paused        = 1'b0;
    clear_polygon();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].res);
    end

    // Random polygons, mostly small, some long
    while (vertices_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:            poly_size = $urandom_range(31, 100);
        1, 2, 3, 4:   poly_size = $urandom_range(9, 30);
        default:      poly_size = $urandom_range(1, 8);
      endcase
      for (int k = 0; k < poly_size; k++) begin
        offer_vertex(rand_coord(), rand_coord(), k == poly_size - 1, 1'b0, '0);
      end
      // long receiver stall with the sender pushing flat out
      if (!held && vertices_sent >= 700) begin
        held        = 1'b1;
        hold_req    = 300;
        steady_left = 80;
      end
      if (!paused && vertices_sent >= 1300) begin
        paused = 1'b1;
        wait_for_results();
      end
    end
    wait_for_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/psa_pkg.sv
hw/rtl/psa_if.sv
hw/rtl/psa_front.sv
hw/rtl/psa_queue.sv
hw/rtl/psa_back.sv
hw/rtl/polygon_area_shoelace.sv
tb/sv/tb.sv
